// ===== rtl/vsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// vsdc_pkg
// Shared constants and types of the vertex set degeneracy checker.
// ----------------------------------------------------------------------------
package vsdc_pkg;

    // Input coordinate fields and configuration register widths.
    localparam int FIELD_W       = 32;
    localparam int NUM_IN_COORDS = 4;
    localparam int DIM_W         = 3;
    localparam int DIM_IDX_W     = 4;
    localparam int TOL_MAG_W     = 31;
    localparam int TSQ_W         = 2 * TOL_MAG_W;
    localparam int PADDR_W       = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic REG_SPACE_DIM = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NEG_TOL  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Classification attached to each item by the front end.
    typedef struct packed {
        logic last;
        logic stored;
    } vsdc_tag_t;

    localparam int TAG_W = $bits(vsdc_tag_t);

endpackage

// ===== rtl/vsdc_fifo.sv =====
// ----------------------------------------------------------------------------
// vsdc_fifo
// Two-entry queue between the front end and the comparison engine.
// ----------------------------------------------------------------------------
module vsdc_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/vsdc_front.sv =====
// ----------------------------------------------------------------------------
// vsdc_front
// Accepts vertex items, trims the coordinates to their working width and
// assigns each vertex a store slot or marks it as overflow.
// ----------------------------------------------------------------------------
module vsdc_front import vsdc_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DIM      = 4,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [FIELD_W-1:0] s_coord_x,
    input  logic signed [FIELD_W-1:0] s_coord_y,
    input  logic signed [FIELD_W-1:0] s_coord_z,
    input  logic signed [FIELD_W-1:0] s_coord_w,
    input  logic                      s_last_vertex,
    output logic                      q_valid,
    input  logic                      q_ready,
    output logic [TAG_W+$clog2(MAX_VERTICES)+MAX_DIM*COORD_WIDTH-1:0] q_data
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CNTW = $clog2(MAX_VERTICES + 1);
    localparam int VW   = MAX_DIM * COORD_WIDTH;
    localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_VERTICES);

    logic [NUM_IN_COORDS-1:0][FIELD_W-1:0] fields;
    logic [VW-1:0]                         coords;
    logic [CNTW-1:0]                       count_reg, count_next;
    vsdc_tag_t                             tag;
    logic                                  accept;

    assign fields = {s_coord_w, s_coord_z, s_coord_y, s_coord_x};

    // Each lane takes the low COORD_WIDTH bits of its sign-extended field;
    // lanes past the fourth carry zero.
    for (genvar j = 0; j < MAX_DIM; j++) begin : g_lane
        if (j < NUM_IN_COORDS) begin : g_used
            logic [2*FIELD_W-1:0] ext;
            assign ext = {{FIELD_W{fields[j][FIELD_W-1]}}, fields[j]};
            assign coords[j*COORD_WIDTH +: COORD_WIDTH] = ext[COORD_WIDTH-1:0];
        end else begin : g_zero
            assign coords[j*COORD_WIDTH +: COORD_WIDTH] = '0;
        end
    end

    assign tag.stored = (count_reg < CNT_MAX);
    assign tag.last   = s_last_vertex;

    assign q_valid = s_valid;
    assign s_ready = q_ready;
    assign q_data  = {tag, count_reg[AW-1:0], coords};
    assign accept  = s_valid && q_ready;

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (s_last_vertex) begin
                count_next = '0;
            end else if (tag.stored) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/vsdc_engine.sv =====
// ----------------------------------------------------------------------------
// vsdc_engine
// Stores each vertex, sweeps the earlier vertices of the curve through a
// squared-distance pipeline and produces the result of the curve.
// ----------------------------------------------------------------------------
module vsdc_engine import vsdc_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DIM      = 4,
    parameter int COORD_WIDTH  = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [FIELD_W-1:0] tolerance,
    input  logic [DIM_W-1:0]   space_dim,
    input  logic               q_valid,
    output logic               q_ready,
    input  logic [TAG_W+$clog2(MAX_VERTICES)+MAX_DIM*COORD_WIDTH-1:0] q_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_degenerate,
    output logic [1:0]         m_status
);

    localparam int CW    = COORD_WIDTH;
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int VW    = MAX_DIM * CW;
    localparam int DW    = CW + 1;
    localparam int SQW   = 2 * DW;
    localparam int PW    = SQW + 1;
    localparam int TW    = SQW + 3;
    localparam int NPAIR = (MAX_DIM + 1) / 2;
    localparam int CMPW  = (TW > TSQ_W) ? TW : TSQ_W;
    localparam logic [DIM_IDX_W-1:0] MAX_DIM_U = DIM_IDX_W'(MAX_DIM);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } vsdc_state_t;

    vsdc_state_t    state_reg, state_next;
    vsdc_tag_t      q_tag;
    logic [AW-1:0]  q_slot;
    logic [VW-1:0]  q_coords;

    logic [VW-1:0]  vert_mem [MAX_VERTICES];
    logic [VW-1:0]  rd_data_reg;
    logic [VW-1:0]  cur_reg;
    logic [AW-1:0]  slot_reg;
    vsdc_tag_t      tag_reg;
    logic [AW-1:0]  rd_idx_reg, rd_idx_next;
    logic           still_deg_reg, still_deg_next;
    logic           overflow_reg, overflow_next;
    logic           m_valid_reg, m_valid_next;
    logic           m_degenerate_reg, m_degenerate_next;
    logic [1:0]     m_status_reg, m_status_next;
    logic           v1_reg, v2_reg, v3_reg, v4_reg;

    logic [DW-1:0]  mag_reg  [MAX_DIM];
    logic [SQW-1:0] sq_reg   [MAX_DIM];
    logic [PW-1:0]  pair_reg [NPAIR];
    logic [TSQ_W-1:0] tsq_reg;
    logic [TW-1:0]  total;
    logic [DIM_IDX_W-1:0] dim_used;
    logic           pop, rd_en, pipe_busy, out_free, far;

    assign {q_tag, q_slot, q_coords} = q_data;

    assign q_ready   = (state_reg == ST_IDLE);
    assign pop       = q_ready && q_valid;
    assign rd_en     = (state_reg == ST_SCAN);
    assign pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_degenerate = m_degenerate_reg;
    assign m_status     = m_status_reg;

    // Out-of-range dimension codes are clamped into 1..MAX_DIM.
    always_comb begin
        dim_used = {1'b0, space_dim};
        if (dim_used == '0) begin
            dim_used = DIM_IDX_W'(1);
        end else if (dim_used > MAX_DIM_U) begin
            dim_used = MAX_DIM_U;
        end
    end

    // Vertex store: one write at each pop of a stored vertex, one registered read per scan cycle.
    always_ff @(posedge aclk) begin
        if (pop && q_tag.stored) begin
            vert_mem[q_slot] <= q_coords;
        end
        if (rd_en) begin
            rd_data_reg <= vert_mem[rd_idx_reg];
        end
    end

    // Distance pipeline: magnitude of difference, square, pair sum, total.
    for (genvar j = 0; j < MAX_DIM; j++) begin : g_lane
        localparam logic [DIM_IDX_W-1:0] LANE_IDX = DIM_IDX_W'(j);
        logic [CW-1:0] cur_c, old_c;
        logic [DW-1:0] diff, mag;

        assign cur_c = cur_reg[j*CW +: CW];
        assign old_c = rd_data_reg[j*CW +: CW];
        assign diff  = {cur_c[CW-1], cur_c} - {old_c[CW-1], old_c};
        assign mag   = diff[DW-1] ? (DW'(0) - diff) : diff;

        always_ff @(posedge aclk) begin
            mag_reg[j] <= (LANE_IDX < dim_used) ? mag : '0;
            sq_reg[j]  <= SQW'(mag_reg[j]) * SQW'(mag_reg[j]);
        end
    end

    for (genvar k = 0; k < NPAIR; k++) begin : g_pair
        if (2 * k + 1 < MAX_DIM) begin : g_two
            always_ff @(posedge aclk) begin
                pair_reg[k] <= PW'(sq_reg[2*k]) + PW'(sq_reg[2*k+1]);
            end
        end else begin : g_one
            always_ff @(posedge aclk) begin
                pair_reg[k] <= PW'(sq_reg[2*k]);
            end
        end
    end

    always_comb begin
        total = '0;
        for (int k = 0; k < NPAIR; k++) begin
            total = total + TW'(pair_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        tsq_reg <= TSQ_W'(tolerance[TOL_MAG_W-1:0]) * TSQ_W'(tolerance[TOL_MAG_W-1:0]);
    end

    // A negative tolerance makes every pair count as too far apart.
    assign far = tolerance[FIELD_W-1] || (CMPW'(total) > CMPW'(tsq_reg));

    always_comb begin
        state_next        = state_reg;
        rd_idx_next       = rd_idx_reg;
        still_deg_next    = still_deg_reg;
        overflow_next     = overflow_reg;
        m_valid_next      = m_valid_reg;
        m_degenerate_next = m_degenerate_reg;
        m_status_next     = m_status_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (v4_reg && far) begin
            still_deg_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (!q_tag.stored) begin
                        overflow_next = 1'b1;
                    end
                    if (q_tag.stored && still_deg_reg && (q_slot != '0)) begin
                        rd_idx_next = '0;
                        state_next  = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                rd_idx_next = rd_idx_reg + 1'b1;
                // Stop early once a pair has been found too far apart.
                if ((rd_idx_reg == slot_reg - 1'b1) || !still_deg_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!tag_reg.last) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    if (tolerance[FIELD_W-1]) begin
                        m_degenerate_next = 1'b0;
                        m_status_next     = STATUS_NEG_TOL;
                    end else if (overflow_reg) begin
                        m_degenerate_next = 1'b0;
                        m_status_next     = STATUS_OVERFLOW;
                    end else begin
                        m_degenerate_next = still_deg_reg;
                        m_status_next     = STATUS_OK;
                    end
                    still_deg_next = 1'b1;
                    overflow_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            still_deg_reg <= 1'b1;
            overflow_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            still_deg_reg <= still_deg_next;
            overflow_reg  <= overflow_next;
            m_valid_reg   <= m_valid_next;
            v1_reg        <= rd_en;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        m_degenerate_reg <= m_degenerate_next;
        m_status_reg     <= m_status_next;
        if (pop) begin
            cur_reg  <= q_coords;
            slot_reg <= q_slot;
            tag_reg  <= q_tag;
        end
    end

endmodule

// ===== rtl/vertex_set_degeneracy_check.sv =====
// ----------------------------------------------------------------------------
// vertex_set_degeneracy_check
// Checks whether all control vertices of a curve lie within a tolerance of
// each other, using squared distances against the squared tolerance.
// ----------------------------------------------------------------------------
// Timing: the result follows once the last vertex has been compared against
// the earlier stored vertices of its curve, read through the single read port
// of the vertex store; the engine takes a new vertex only after the previous
// one is finished, and a two-entry queue in front of it buffers input.
// Reset: synchronous; control state and config registers return to defaults,
// the vertex store is not cleared and needs no clearing pass.
module vertex_set_degeneracy_check import vsdc_pkg::*; #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_DIM      = 4,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [FIELD_W-1:0]        pwdata,
    output logic [FIELD_W-1:0]        prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [FIELD_W-1:0] s_coord_x,
    input  logic signed [FIELD_W-1:0] s_coord_y,
    input  logic signed [FIELD_W-1:0] s_coord_z,
    input  logic signed [FIELD_W-1:0] s_coord_w,
    input  logic                      s_last_vertex,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_degenerate,
    output logic [1:0]                m_status
);

    localparam int QW = TAG_W + $clog2(MAX_VERTICES) + MAX_DIM * COORD_WIDTH;
    localparam logic [DIM_W-1:0] SPACE_DIM_RESET = 3'd3;

    logic [FIELD_W-1:0] tolerance_reg, tolerance_next;
    logic [DIM_W-1:0]   space_dim_reg, space_dim_next;
    logic               cfg_write;
    logic               fq_valid, fq_ready, eq_valid, eq_ready;
    logic [QW-1:0]      fq_data, eq_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        tolerance_next = tolerance_reg;
        space_dim_next = space_dim_reg;
        if (cfg_write) begin
            unique case (paddr[2])
                REG_TOLERANCE: tolerance_next = pwdata;
                REG_SPACE_DIM: space_dim_next = pwdata[DIM_W-1:0];
                default:       tolerance_next = tolerance_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_TOLERANCE: prdata = tolerance_reg;
                REG_SPACE_DIM: prdata = FIELD_W'(space_dim_reg);
                default:       prdata = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tolerance_reg <= '0;
            space_dim_reg <= SPACE_DIM_RESET;
        end else begin
            tolerance_reg <= tolerance_next;
            space_dim_reg <= space_dim_next;
        end
    end

    vsdc_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DIM      (MAX_DIM),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .s_coord_w     (s_coord_w),
        .s_last_vertex (s_last_vertex),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    vsdc_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (eq_valid),
        .out_ready (eq_ready),
        .out_data  (eq_data)
    );

    vsdc_engine #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DIM      (MAX_DIM),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tolerance    (tolerance_reg),
        .space_dim    (space_dim_reg),
        .q_valid      (eq_valid),
        .q_ready      (eq_ready),
        .q_data       (eq_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_degenerate (m_degenerate),
        .m_status     (m_status)
    );

    // A result carries one of the defined status codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK) || (m_status == STATUS_NEG_TOL) ||
                    (m_status == STATUS_OVERFLOW))
        else $error("result with undefined status code");

    // An error status never reports a degenerate vertex set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STATUS_OK)) |-> !m_degenerate)
        else $error("degenerate flag set together with an error status");

    // No result is pending right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vertex set degeneracy checker. Curves of
// vertices are streamed through the valid/ready input while tolerance and
// dimension are reprogrammed between phases over the register port. A local
// model predicts the verdict of each closed curve and every result that
// leaves the block is compared field by field.
// ----------------------------------------------------------------------------
module tb;
    import vsdc_pkg::*;

    localparam int          MAX_VERTICES     = 64;
    localparam int          CLK_PERIOD       = 20;
    localparam int          SETTLE_CYCLES    = MAX_VERTICES + 16;
    localparam int          LONG_HOLD_CYCLES = 400;
    localparam int          RANDOM_ITEMS     = 910;
    localparam int          CALM_ITEMS       = 40;
    localparam longint      TIMEOUT_NS       = 64'd12_000_000;
    localparam int unsigned SCATTER          = 32'hffff_ffff;
    localparam int unsigned REACH_CAP        = 32'h3fff_ffff;

    localparam logic [FIELD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] COORD_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic signed [FIELD_W-1:0] w;
        logic                      last;
    } vertex_t;

    typedef struct packed {
        logic       degenerate;
        logic [1:0] status;
    } verdict_t;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [PADDR_W-1:0]        paddr         = '0;
    logic [FIELD_W-1:0]        pwdata        = '0;
    logic [FIELD_W-1:0]        prdata;
    logic                      pready;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic signed [FIELD_W-1:0] s_coord_x     = '0;
    logic signed [FIELD_W-1:0] s_coord_y     = '0;
    logic signed [FIELD_W-1:0] s_coord_z     = '0;
    logic signed [FIELD_W-1:0] s_coord_w     = '0;
    logic                      s_last_vertex = 1'b0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic                      m_degenerate;
    logic [1:0]                m_status;

    // Stimulus and checking bookkeeping.
    vertex_t  vertex_backlog[$];
    verdict_t verdicts_due[$];
    int       items_queued  = 0;
    int       mismatches    = 0;
    bit       in_taken      = 1'b0;
    bit       calm          = 1'b0;
    bit       hold_request  = 1'b0;
    bit       hold_done     = 1'b0;
    int       idle_pct      = 0;
    int       gap_left      = 0;
    int       stall_left    = 0;
    int       hold_left     = 0;

    // Model of the block: the open curve and the programmed registers.
    logic signed [FIELD_W-1:0] curve_pts [MAX_VERTICES][NUM_IN_COORDS];
    int                        pts_held      = 0;
    bit                        all_close     = 1'b1;
    bit                        store_overrun = 1'b0;
    logic signed [FIELD_W-1:0] tol_q         = '0;
    logic [DIM_W-1:0]          dim_q         = 3'd3;

    vertex_set_degeneracy_check u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_coord_x     (s_coord_x),
        .s_coord_y     (s_coord_y),
        .s_coord_z     (s_coord_z),
        .s_coord_w     (s_coord_w),
        .s_last_vertex (s_last_vertex),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_degenerate  (m_degenerate),
        .m_status      (m_status)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Squared distance against squared tolerance, exact at full width.
    function automatic bit pair_too_far(input int newer, input int older);
        int                   n;
        logic signed [FIELD_W:0] d;
        logic [FIELD_W:0]     mag;
        logic [2*FIELD_W+3:0] dist_sq;
        logic [2*FIELD_W+3:0] tol_sq;
        n = (dim_q == 0) ? 1 : ((dim_q > NUM_IN_COORDS) ? NUM_IN_COORDS : int'(dim_q));
        if (tol_q < 0)
            return 1'b1;
        dist_sq = '0;
        for (int c = 0; c < n; c++) begin
            d = {curve_pts[newer][c][FIELD_W-1], curve_pts[newer][c]}
              - {curve_pts[older][c][FIELD_W-1], curve_pts[older][c]};
            mag = d[FIELD_W] ? -d : d;
            dist_sq = dist_sq + mag * mag;
        end
        tol_sq = tol_q[TOL_MAG_W-1:0] * tol_q[TOL_MAG_W-1:0];
        return dist_sq > tol_sq;
    endfunction

    task automatic absorb_vertex(input vertex_t v);
        verdict_t verdict;
        if (pts_held < MAX_VERTICES) begin
            curve_pts[pts_held][0] = v.x;
            curve_pts[pts_held][1] = v.y;
            curve_pts[pts_held][2] = v.z;
            curve_pts[pts_held][3] = v.w;
            for (int i = 0; i < pts_held && all_close; i++)
                if (pair_too_far(pts_held, i))
                    all_close = 1'b0;
            pts_held++;
        end else begin
            store_overrun = 1'b1;
        end
        if (v.last) begin
            if (tol_q < 0) begin
                verdict.degenerate = 1'b0;
                verdict.status     = STATUS_NEG_TOL;
            end else if (store_overrun) begin
                verdict.degenerate = 1'b0;
                verdict.status     = STATUS_OVERFLOW;
            end else begin
                verdict.degenerate = all_close;
                verdict.status     = STATUS_OK;
            end
            verdicts_due.push_back(verdict);
            pts_held      = 0;
            all_close     = 1'b1;
            store_overrun = 1'b0;
        end
    endtask

    // Results are checked before the input item of the same edge is absorbed.
    always @(posedge aclk) begin : observe
        verdict_t due;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                flag_mismatch("result arrived with no curve closed");
            end else begin
                due = verdicts_due.pop_front();
                if (m_degenerate !== due.degenerate)
                    flag_mismatch($sformatf("degenerate %b, expected %b",
                                            m_degenerate, due.degenerate));
                if (m_status !== due.status)
                    flag_mismatch($sformatf("status %0d, expected %0d",
                                            m_status, due.status));
            end
        end
        if (in_taken)
            absorb_vertex({s_coord_x, s_coord_y, s_coord_z, s_coord_w, s_last_vertex});
    end

    always @(negedge aclk) begin : feed_vertices
        vertex_t next_v;
        if (!s_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (vertex_backlog.size() != 0) begin
                next_v = vertex_backlog.pop_front();
                s_coord_x     <= next_v.x;
                s_coord_y     <= next_v.y;
                s_coord_z     <= next_v.z;
                s_coord_w     <= next_v.w;
                s_last_vertex <= next_v.last;
                s_valid       <= 1'b1;
                if (!calm && $urandom_range(0, 99) < idle_pct)
                    gap_left = $urandom_range(1, 19);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The one long hold lets the block back up until it refuses input.
    always @(negedge aclk) begin : pace_results
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 18);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic reg_sel, input logic [FIELD_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_TOLERANCE)
            tol_q = value;
        else
            dim_q = value[DIM_W-1:0];
        @(posedge aclk);
    endtask

    task automatic queue_vertex(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                                input logic [FIELD_W-1:0] z, input logic [FIELD_W-1:0] w,
                                input logic last);
        vertex_backlog.push_back({x, y, z, w, last});
        items_queued++;
    endtask

    // Vertices scattered around a random hub, or fully random when scattered.
    task automatic queue_curve(input int n, input int unsigned reach);
        logic [FIELD_W-1:0] hub [NUM_IN_COORDS];
        logic [FIELD_W-1:0] pt  [NUM_IN_COORDS];
        int unsigned        r;
        r = (reach > REACH_CAP) ? REACH_CAP : reach;
        for (int c = 0; c < NUM_IN_COORDS; c++)
            hub[c] = $urandom;
        for (int i = 0; i < n; i++) begin
            for (int c = 0; c < NUM_IN_COORDS; c++)
                pt[c] = (reach == SCATTER) ? $urandom
                                           : hub[c] + $urandom_range(0, 2 * r) - r;
            queue_vertex(pt[0], pt[1], pt[2], pt[3], i == n - 1);
        end
    endtask

    // A reach of a quarter tolerance keeps every pair inside it.
    function automatic int unsigned pick_reach();
        int unsigned mag;
        mag = tol_q[FIELD_W-1] ? 32'd4096 : tol_q;
        case ($urandom_range(0, 7))
            0:       return 0;
            1, 2, 3: return mag >> 2;
            4:       return mag >> 1;
            5:       return mag;
            6:       return $urandom_range(0, REACH_CAP);
            default: return SCATTER;
        endcase
    endfunction

    function automatic int pick_length();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 1;
        else if (roll < 14)
            return $urandom_range(2, 6);
        else if (roll < 19)
            return $urandom_range(7, 20);
        else
            return $urandom_range(21, 40);
    endfunction

    task automatic pick_settings();
        logic [FIELD_W-1:0] tol;
        case ($urandom_range(0, 9))
            0:       tol = '0;
            1:       tol = COORD_MAX;
            2:       tol = ($urandom_range(0, 1) != 0) ? COORD_MIN : ($urandom | COORD_MIN);
            3, 4, 5: tol = $urandom_range(1, 32'h0010_0000);
            default: tol = $urandom_range(1, 32'h7fff_fffe);
        endcase
        write_reg(REG_TOLERANCE, tol);
        write_reg(REG_SPACE_DIM, $urandom_range(0, 7));
    endtask

    // Lets the block run dry, then waits out any comparison still in flight.
    task automatic wait_for_idle();
        while (vertex_backlog.size() != 0 || s_valid || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic pick_idling();
        case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            default: idle_pct = 35;
        endcase
    endtask

    initial begin : stimulus
        int phase;
        int budget;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        idle_pct = 20;

        // Reset settings: zero tolerance, three coordinates.
        queue_vertex('0, '0, '0, '0, 1'b1);
        queue_vertex(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b0);
        queue_vertex(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1);
        queue_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
        wait_for_idle();

        // Widest tolerance: a distance equal to it passes, one step more fails.
        write_reg(REG_TOLERANCE, COORD_MAX);
        write_reg(REG_SPACE_DIM, 3'd4);
        queue_vertex(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        queue_vertex(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        queue_vertex('0, '0, '0, '0, 1'b0);
        queue_vertex(COORD_MAX, '0, '0, '0, 1'b1);
        queue_vertex('0, '0, '0, '0, 1'b0);
        queue_vertex(COORD_MAX, 32'd1, '0, '0, 1'b1);
        // This curve stays open across the next register change.
        queue_vertex('0, COORD_MAX, COORD_MIN, '0, 1'b0);
        wait_for_idle();

        // A dimension of zero uses one coordinate; the tolerance becomes 1.0.
        write_reg(REG_SPACE_DIM, 3'd0);
        write_reg(REG_TOLERANCE, 32'h0001_0000);
        queue_vertex(32'h0001_0000, COORD_MIN, COORD_MAX, 32'h1234_5678, 1'b0);
        queue_vertex('0, 32'd5, '0, COORD_MIN, 1'b1);
        wait_for_idle();

        // Negative tolerance, with a dimension beyond the maximum.
        write_reg(REG_SPACE_DIM, 3'd7);
        write_reg(REG_TOLERANCE, COORD_MIN);
        queue_vertex('0, '0, '0, '0, 1'b1);
        queue_vertex(32'd5, 32'd5, 32'd5, 32'd5, 1'b0);
        queue_vertex(32'd5, 32'd5, 32'd5, 32'd5, 1'b1);
        wait_for_idle();

        phase = 0;
        while (items_queued < RANDOM_ITEMS) begin
            pick_idling();
            if (phase == 3 || phase == 6) begin
                // Full store, then overflow; the second pass adds a bad tolerance.
                write_reg(REG_TOLERANCE, (phase == 3) ? $urandom_range(1, 32'h0010_0000)
                                                      : ($urandom | COORD_MIN));
                write_reg(REG_SPACE_DIM, $urandom_range(1, 4));
                queue_vertex($urandom, $urandom, $urandom, $urandom, 1'b1);
                queue_curve(MAX_VERTICES, tol_q[FIELD_W-1] ? pick_reach() : (tol_q >> 2));
                queue_curve(MAX_VERTICES + $urandom_range(1, 4), pick_reach());
            end else begin
                pick_settings();
                budget = items_queued + $urandom_range(40, 90);
                while (items_queued < budget)
                    queue_curve(pick_length(), pick_reach());
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, 3))
                        queue_vertex($urandom, $urandom, $urandom, $urandom, 1'b0);
                if (phase == 2)
                    hold_request = 1'b1;
            end
            wait_for_idle();
            phase++;
        end

        // Closing stretch at full rate on both sides.
        calm     = 1'b1;
        idle_pct = 0;
        pick_settings();
        budget = items_queued + CALM_ITEMS;
        while (items_queued < budget)
            queue_curve(pick_length(), pick_reach());
        wait_for_idle();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
